### rtl/rcmio_pkg.sv
package rcmio_pkg;

    // Bus and store geometry
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned MEM_DEPTH = 65536;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    // Memory map
    localparam logic [ADDR_W-1:0] IO_LOW    = 16'hD000;
    localparam logic [ADDR_W-1:0] IO_HIGH   = 16'hDFFF;
    localparam logic [ADDR_W-1:0] ROM_LOW   = 16'hE000;
    localparam logic [ADDR_W-1:0] ROM_HIGH  = 16'hEFFF;
    localparam logic [ADDR_W-1:0] TOP_LOW   = 16'hFF00;
    localparam logic [ADDR_W-1:0] KEY_DATA  = 16'hD010;
    localparam logic [ADDR_W-1:0] KEY_CTRL  = 16'hD011;
    localparam logic [ADDR_W-1:0] DISP_DATA = 16'hD012;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;
    localparam logic [CHAR_W-1:0] CH_DEL    = 7'h7F;
    localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
    localparam logic [DATA_W-1:0] KEY_CTRLA = 8'h01;
    localparam logic [DATA_W-1:0] KEY_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] KEY_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] KEY_STROBE = 8'h80;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_KEY     = 2'd2,
        MODE_PRELOAD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        WS_OK      = 2'd0,
        WS_ROM     = 2'd1,
        WS_ILLEGAL = 2'd2
    } wstat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

### rtl/retro_computer_memory_io_bus.sv
// Sequence: an input transfer in IDLE loads the result fields, READ captures the
// store byte and RESP holds the result until m_tready; one access is in flight at a
// time, set by the registered read of the single-port byte store and the result hand-off.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
// 65536 store bytes with s_tready low, then the block goes idle.
module retro_computer_memory_io_bus (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: address[15:0], write_data[23:16], key_code[31:24]
    input  logic [rcmio_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: mode[1:0]
    input  logic [rcmio_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: read_data[7:0], char_valid[8], char_out[15:9],
    //          reset_request[16], write_status[18:17], zero fill[23:19]
    output logic [rcmio_pkg::M_TDATA_W-1:0]     m_tdata
);

    import rcmio_pkg::*;

    cmd_t    cmd;
    status_t status;

    rcmio_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcmio_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .status  (status)
    );

endmodule

### rtl/rcmio_ram.sv
module rcmio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rcmio_ctrl.sv
module rcmio_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rcmio_pkg::status_t status,
    output rcmio_pkg::cmd_t   cmd
);

    import rcmio_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_RESP;
            ST_RESP:  if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_CLEAR: cmd.clear_en = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ:  cmd.capture = 1'b1;
            ST_RESP:  m_tvalid = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

### rtl/rcmio_dp.sv
module rcmio_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcmio_pkg::cmd_t                     cmd,
    input  logic [rcmio_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [rcmio_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic [rcmio_pkg::M_TDATA_W-1:0]     m_tdata,
    output rcmio_pkg::status_t                  status
);

    import rcmio_pkg::*;

    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] key_code;
    mode_t             mode;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [DATA_W-1:0] key_data_reg, key_data_next;
    logic [DATA_W-1:0] key_ctrl_reg, key_ctrl_next;

    logic [DATA_W-1:0] rd_reg;
    logic              cv_reg, cv_next;
    logic [CHAR_W-1:0] co_reg, co_next;
    logic              rr_reg, rr_next;
    wstat_t            ws_reg, ws_next;
    logic              use_ram_reg, use_ram_next;
    logic [DATA_W-1:0] rd_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic [CHAR_W-1:0] ch;
    logic [DATA_W-1:0] key_fix;

    assign address    = s_tdata[15:0];
    assign write_data = s_tdata[23:16];
    assign key_code   = s_tdata[31:24];
    assign mode       = mode_t'(s_tuser);
    assign ch         = write_data[CHAR_W-1:0];
    assign key_fix    = (key_code == KEY_LF) ? KEY_CR : key_code;

    // Decode a clearing write or one access: store writes, keyboard bytes and result fields
    always_comb begin
        ram_we        = 1'b0;
        ram_addr      = address;
        ram_wdata     = write_data;
        key_data_next = key_data_reg;
        key_ctrl_next = key_ctrl_reg;
        rd_next       = '0;
        cv_next       = 1'b0;
        co_next       = '0;
        rr_next       = 1'b0;
        ws_next       = WS_OK;
        use_ram_next  = 1'b0;
        if (cmd.clear_en) begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.load) begin
            case (mode)
                MODE_READ: begin
                    if (address == KEY_DATA) begin
                        rd_next       = key_data_reg;
                        key_data_next = '0;
                        key_ctrl_next = '0;
                    end else if (address == KEY_CTRL) begin
                        rd_next = key_ctrl_reg;
                    end else begin
                        use_ram_next = 1'b1;
                    end
                end
                MODE_WRITE: begin
                    if (address >= IO_LOW && address <= IO_HIGH) begin
                        if (address == KEY_DATA) begin
                            key_data_next = write_data;
                        end else if (address == KEY_CTRL) begin
                            key_ctrl_next = write_data;
                        end else if (address == DISP_DATA) begin
                            // the display byte reads back as zero
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                            if (ch != CH_NUL && ch != CH_DEL && ch != CH_LF) begin
                                cv_next = 1'b1;
                                co_next = (ch == CH_CR) ? CH_LF : ch;
                            end
                        end else begin
                            ram_we = 1'b1;
                        end
                    end else if (address >= ROM_LOW && address <= ROM_HIGH) begin
                        ws_next = WS_ROM;
                    end else if (address < TOP_LOW) begin
                        ram_we = 1'b1;
                    end else begin
                        ws_next = WS_ILLEGAL;
                    end
                end
                MODE_KEY: begin
                    if (key_code == KEY_CTRLA) begin
                        rr_next = 1'b1;
                    end else begin
                        key_data_next = {1'b1, key_fix[CHAR_W-1:0]};
                        key_ctrl_next = KEY_STROBE;
                    end
                end
                MODE_PRELOAD: begin
                    if (address == KEY_DATA) begin
                        key_data_next = write_data;
                    end else if (address == KEY_CTRL) begin
                        key_ctrl_next = write_data;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
                default: ram_we = 1'b0;
            endcase
        end
    end

    assign clr_cnt_next      = cmd.clear_en ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;
    assign status.clear_last = (clr_cnt_reg == '1);

    // Control state and keyboard bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            key_data_reg <= '0;
            key_ctrl_reg <= '0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            key_data_reg <= key_data_next;
            key_ctrl_reg <= key_ctrl_next;
        end
    end

    // Result register: fields on load, store byte on capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_reg      <= rd_next;
            cv_reg      <= cv_next;
            co_reg      <= co_next;
            rr_reg      <= rr_next;
            ws_reg      <= ws_next;
            use_ram_reg <= use_ram_next;
        end else if (cmd.capture && use_ram_reg) begin
            rd_reg <= ram_rdata;
        end
    end

    rcmio_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_tdata = {5'd0, ws_reg, rr_reg, co_reg, cv_reg, rd_reg};

endmodule

### rtl/rcmio_checker.sv
module rcmio_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rcmio_pkg::M_TDATA_W-1:0]     m_tdata
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Take no access while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    // Result follows each input transfer, after the READ state
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result latency broken");

    // Write status never carries the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:17] != 2'b11)
        else $error("bad write status");

    // Character is zero unless flagged, and never zero when flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == (m_tdata[15:9] != 7'd0)))
        else $error("character flag mismatch");

endmodule

bind retro_computer_memory_io_bus rcmio_checker u_rcmio_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
